### sv/kwmh_pkg.sv
// Shared types and constants for the k-way merge heap.
// Used by kwmh_ram and k_way_merge_heap; no dependencies.
package kwmh_pkg;

  localparam int LISTS = 16;
  localparam int IDX_W = $clog2(LISTS);
  localparam int CNT_W = $clog2(LISTS + 1);
  localparam int CH_W  = IDX_W + 2;
  localparam int KEY_W = 32;
  localparam int SRC_W = 4;

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_BUILD   = 2'd1,
    ACT_REFILL  = 2'd2,
    ACT_EXHAUST = 2'd3
  } action_e;

  typedef struct packed {
    action_e                  action;
    logic signed [KEY_W-1:0]  value;
  } in_t;

  typedef struct packed {
    logic signed [KEY_W-1:0]  min_value;
    logic [SRC_W-1:0]         source_list;
    logic                     empty_res;
  } out_t;

  typedef struct packed {
    logic signed [KEY_W-1:0]  key;
    logic [SRC_W-1:0]         src;
  } entry_t;

endpackage

### sv/kwmh_ram.sv
// Heap entry storage: one write port, one read port with registered data.
// Depends on kwmh_pkg.
module kwmh_ram (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [kwmh_pkg::IDX_W-1:0] waddr_i,
  input  kwmh_pkg::entry_t          wdata_i,
  input  logic [kwmh_pkg::IDX_W-1:0] raddr_i,
  output kwmh_pkg::entry_t          rdata_o
);
  import kwmh_pkg::*;

  entry_t mem_q [LISTS];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/k_way_merge_heap.sv
// K-way merge engine on a binary min-heap of (key, source) pairs.
// Load appends a key while the heap is not full and gives no result. Refill/exhaust
// fetch the key in LOADH, sift it down via LEFT, RIGHT and CMP per level, write it in
// PLACE, read the root in ROOT and report in RES; an empty heap goes straight to ROOT.
// Build runs one sift (LOADH, levels, PLACE) per internal node, then ROOT and RES.
// Input is taken again in the cycle the result is raised; a pending result does not block.
// Reset (async, active low) empties the heap; RAM contents are not cleared.
module k_way_merge_heap (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  kwmh_pkg::in_t   in_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output kwmh_pkg::out_t  out_o
);
  import kwmh_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOADH,
    S_LEFT,
    S_RIGHT,
    S_CMP,
    S_PLACE,
    S_ROOT,
    S_RES
  } state_e;

  state_e             state_q;
  action_e            op_q;
  logic [CNT_W-1:0]   count_q;
  logic [IDX_W-1:0]   i_q;
  logic [IDX_W-1:0]   bi_q;
  logic [KEY_W-1:0]   value_q;
  entry_t             hold_q;
  entry_t             best_q;
  logic [IDX_W-1:0]   best_idx_q;
  logic               out_valid_q;
  out_t               out_q;

  logic               in_xfer;
  logic [CH_W-1:0]    l_w;
  logic [CH_W-1:0]    r_w;
  logic [CH_W-1:0]    cnt_w;
  logic               l_ok;
  logic               r_ok;
  logic               lt;
  logic               sel_r;
  entry_t             best_e;
  logic [IDX_W-1:0]   best_i;
  logic [IDX_W-1:0]   build_start;
  logic               not_full;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  entry_t             ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  entry_t             ram_rdata;

  kwmh_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assign l_w         = CH_W'({i_q, 1'b1});
  assign r_w         = CH_W'({i_q, 1'b0}) + CH_W'(2);
  assign cnt_w       = CH_W'(count_q);
  assign l_ok        = (l_w < cnt_w);
  assign r_ok        = (r_w < cnt_w);
  assign not_full    = (count_q < CNT_W'(LISTS));
  assign build_start = IDX_W'((count_q >> 1) - CNT_W'(1));

  // shared key comparator
  assign lt     = ($signed(ram_rdata.key) < $signed(best_q.key));
  assign sel_r  = r_ok && lt;
  assign best_e = sel_r ? ram_rdata : best_q;
  assign best_i = sel_r ? IDX_W'(r_w) : best_idx_q;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = i_q;
    ram_wdata = hold_q;
    ram_raddr = '0;
    case (state_q)
      S_IDLE: begin
        case (in_i.action)
          ACT_LOAD: begin
            ram_we    = in_xfer && not_full;
            ram_waddr = IDX_W'(count_q);
            ram_wdata = '{key: in_i.value, src: SRC_W'(count_q)};
          end
          ACT_BUILD:   ram_raddr = build_start;
          ACT_REFILL:  ram_raddr = '0;
          ACT_EXHAUST: ram_raddr = IDX_W'(count_q - CNT_W'(1));
          default:     ram_raddr = '0;
        endcase
      end
      S_LEFT: begin
        ram_raddr = IDX_W'(l_w);
      end
      S_RIGHT: begin
        ram_raddr = IDX_W'(r_w);
      end
      S_CMP: begin
        ram_we    = (best_i != i_q);
        ram_wdata = best_e;
      end
      S_PLACE: begin
        ram_we    = 1'b1;
        ram_raddr = bi_q - IDX_W'(1);
      end
      default: ram_raddr = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= ACT_LOAD;
      count_q     <= '0;
      i_q         <= '0;
      bi_q        <= '0;
      value_q     <= '0;
      hold_q      <= '0;
      best_q      <= '0;
      best_idx_q  <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_RES) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            op_q    <= in_i.action;
            value_q <= in_i.value;
            case (in_i.action)
              ACT_LOAD: begin
                if (not_full) begin
                  count_q <= count_q + CNT_W'(1);
                end
              end
              ACT_BUILD: begin
                if (count_q >= CNT_W'(2)) begin
                  bi_q    <= build_start;
                  i_q     <= build_start;
                  state_q <= S_LOADH;
                end else begin
                  state_q <= S_ROOT;
                end
              end
              ACT_REFILL: begin
                i_q     <= '0;
                state_q <= (count_q == '0) ? S_ROOT : S_LOADH;
              end
              ACT_EXHAUST: begin
                i_q <= '0;
                if (count_q == '0) begin
                  state_q <= S_ROOT;
                end else begin
                  count_q <= count_q - CNT_W'(1);
                  state_q <= S_LOADH;
                end
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_LOADH: begin
          if (op_q == ACT_REFILL) begin
            hold_q <= '{key: value_q, src: ram_rdata.src};
          end else begin
            hold_q <= ram_rdata;
          end
          state_q <= S_LEFT;
        end
        S_LEFT: begin
          best_q     <= hold_q;
          best_idx_q <= i_q;
          state_q    <= l_ok ? S_RIGHT : S_PLACE;
        end
        S_RIGHT: begin
          if (lt) begin
            best_q     <= ram_rdata;
            best_idx_q <= IDX_W'(l_w);
          end
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (best_i != i_q) begin
            i_q     <= best_i;
            state_q <= S_LEFT;
          end else begin
            state_q <= S_PLACE;
          end
        end
        S_PLACE: begin
          if (op_q == ACT_BUILD && bi_q != '0) begin
            bi_q    <= bi_q - IDX_W'(1);
            i_q     <= bi_q - IDX_W'(1);
            state_q <= S_LOADH;
          end else begin
            state_q <= S_ROOT;
          end
        end
        S_ROOT: begin
          state_q <= S_RES;
        end
        S_RES: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            if (count_q == '0) begin
              out_q <= '{min_value: '0, source_list: '0, empty_res: 1'b1};
            end else begin
              out_q <= '{min_value: ram_rdata.key, source_list: ram_rdata.src,
                         empty_res: 1'b0};
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(LISTS))
    else $error("heap count above capacity");

  a_load_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && in_i.action == ACT_LOAD && not_full
    |=> count_q == CNT_W'($past(count_q) + CNT_W'(1)))
    else $error("load did not grow heap");

  a_busy_after_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && in_i.action != ACT_LOAD |=> in_stall_o)
    else $error("non-load transfer did not start work");

  a_empty_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.empty_res |-> out_o.min_value == '0 && out_o.source_list == '0)
    else $error("empty result carries data");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_RES))
    else $error("result raised outside report step");

endmodule
